/* design/ecc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ecc_pkg;

  // calendar constants
  localparam logic [16:0] SEC_PER_DAY  = 17'd86400;
  localparam logic [11:0] SEC_PER_HOUR = 12'd3600;
  localparam logic [5:0]  SEC_PER_MIN  = 6'd60;
  localparam logic [9:0]  DAY_SPLIT_DIV = 10'd675;       // 86400 / 128

  // day number of 1970-01-01 counted from March 1 of year 0, plus one for day - 1
  localparam logic signed [23:0] EPOCH_DAY_M1 = 24'sd719469;

  // seconds to days: offset of 675 * 2^22 keeps the dividend positive
  localparam logic signed [33:0] SPLIT_OFS   = 34'sd2831155200;
  localparam logic [17:0]        DIV675_HI_M = 18'd198842;     // ceil(2^27 / 675)
  localparam logic [26:0]        DIV675_LO_M = 27'd101806633;  // ceil(2^36 / 675)
  localparam logic signed [23:0] DAY_BIAS    = 24'sd3474836;   // 2^22 - epoch day

  // year estimate floor((2000 g + 2956) / 730485), biased by 8192 years
  localparam logic signed [35:0] YEAR_NUM_BIAS = 36'sd5984136076;
  localparam logic [20:0]        DIV_YR_M      = 21'd1505180;  // floor(2^40 / 730485)
  localparam logic [19:0]        YEAR_DIV      = 20'd730485;
  localparam logic signed [15:0] YEAR_BIAS     = 16'sd8192;

  // reciprocals for the narrow constant divisions
  localparam logic [12:0] DIV100_M = 13'd5243;    // ceil(2^19 / 100)
  localparam logic signed [15:0] DIV100_BIAS = 16'sd8000;
  localparam logic signed [8:0]  DIV100_CORR = 9'sd80;
  localparam logic [13:0] HOUR_M   = 14'd9321;    // ceil(2^21 / 225)
  localparam logic [10:0] MIN_M    = 11'd1093;    // ceil(2^14 / 15)
  localparam logic [14:0] MI_M     = 15'd21932;   // ceil(2^24 / 765)

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } tod_t;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } date_t;

  // month 1..12 to march-based month 0..11, out-of-range codes wrap mod 12
  function automatic logic [3:0] march_month(input logic [3:0] m);
    logic [3:0] r;
    if (m < 4'd3) begin
      r = m + 4'd9;
    end else if (m == 4'd15) begin
      r = 4'd0;
    end else begin
      r = m - 4'd3;
    end
    return r;
  endfunction

  // first day of a march-based month, (mm * 306 + 5) / 10
  function automatic logic [8:0] month_offset(input logic [3:0] mm);
    logic [8:0] r;
    case (mm)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // floor(y / 100) for -8000 <= y < 17600
  function automatic logic signed [8:0] div100(input logic signed [15:0] y);
    logic [15:0] yb;
    logic [27:0] p;
    yb = y + DIV100_BIAS;
    p  = 28'(yb[14:0]) * 28'(DIV100_M);
    return $signed({1'b0, p[26:19]}) - DIV100_CORR;
  endfunction

  // days from March 1 of year 0 to March 1 of year y, f100 = floor(y / 100)
  function automatic logic signed [23:0] days_before(input logic signed [15:0] y,
                                                      input logic signed [8:0]  f100);
    logic signed [23:0] ye;
    logic signed [23:0] fe;
    ye = 24'(y);
    fe = 24'(f100);
    return ye * 24'sd365 + (ye >>> 2) - fe + (fe >>> 2);
  endfunction

endpackage

`default_nettype wire

/* design/ecc_date_join.sv */
`timescale 1ns / 1ps
`default_nettype none

// date and time to epoch seconds, four register stages
module ecc_date_join (
  input  wire logic        clk,
  input  wire logic [13:0] year,
  input  wire logic [3:0]  month,
  input  wire logic [4:0]  day,
  input  wire logic [4:0]  hour,
  input  wire logic [5:0]  minute,
  input  wire logic [5:0]  second,
  output logic      [38:0] secs
);

  logic [3:0]         mm;
  logic signed [15:0] yy1, yy2;
  logic [8:0]         moff1, moff2;
  logic [4:0]         day1, day2;
  logic [16:0]        tod1, tod2, tod3;
  logic signed [8:0]  f100_2;
  logic signed [23:0] rel3;
  logic signed [40:0] secs_full;

  assign mm = ecc_pkg::march_month(month);

  // stage 1: march-based month, year shift, time of day
  always_ff @(posedge clk) begin
    yy1   <= $signed({2'b00, year}) - ((mm >= 4'd10) ? 16'sd1 : 16'sd0);
    moff1 <= ecc_pkg::month_offset(mm);
    day1  <= day;
    tod1  <= 17'(hour) * 17'(ecc_pkg::SEC_PER_HOUR) + 17'(minute) * 17'(ecc_pkg::SEC_PER_MIN)
           + 17'(second);
  end

  // stage 2: century count
  always_ff @(posedge clk) begin
    yy2    <= yy1;
    f100_2 <= ecc_pkg::div100(yy1);
    moff2  <= moff1;
    day2   <= day1;
    tod2   <= tod1;
  end

  // stage 3: day number relative to the epoch
  always_ff @(posedge clk) begin
    rel3 <= ecc_pkg::days_before(yy2, f100_2) + $signed({15'd0, moff2})
          + $signed({19'd0, day2}) - ecc_pkg::EPOCH_DAY_M1;
    tod3 <= tod2;
  end

  // stage 4: scale to seconds, wraps to 39 bits
  assign secs_full = 41'(rel3) * $signed({24'd0, ecc_pkg::SEC_PER_DAY})
                   + $signed({24'd0, tod3});

  always_ff @(posedge clk) begin
    secs <= secs_full[38:0];
  end

endmodule

`default_nettype wire

/* design/ecc_epoch_split.sv */
`timescale 1ns / 1ps
`default_nettype none

// floor split of epoch seconds into day number and second of day, four stages
module ecc_epoch_split (
  input  wire logic               clk,
  input  wire logic signed [38:0] epoch_seconds,
  output logic signed      [23:0] g,
  output logic             [16:0] sod
);

  logic signed [31:0] u;
  logic signed [33:0] v_s;
  logic [16:0]        vh, vh1;
  logic [34:0]        ph;
  logic [6:0]         qh1, qh2, qh3;
  logic [15:0]        vl1;
  logic [6:0]         lo1, lo2, lo3;
  logic [16:0]        rh;
  logic [25:0]        w2, w3;
  logic [52:0]        pl;
  logic [15:0]        ql3;
  logic [25:0]        rl;

  // divide by 128 first, the rest is a division by 675 in two digits
  assign u   = epoch_seconds[38:7];
  assign v_s = 34'(u) + ecc_pkg::SPLIT_OFS;
  assign vh  = v_s[32:16];
  assign ph  = 35'(vh) * 35'(ecc_pkg::DIV675_HI_M);

  always_ff @(posedge clk) begin
    qh1 <= ph[33:27];
    vh1 <= vh;
    vl1 <= v_s[15:0];
    lo1 <= epoch_seconds[6:0];
  end

  // high digit remainder joins the low half
  assign rh = vh1 - 17'(qh1) * 17'(ecc_pkg::DAY_SPLIT_DIV);

  always_ff @(posedge clk) begin
    w2  <= {rh[9:0], vl1};
    qh2 <= qh1;
    lo2 <= lo1;
  end

  assign pl = 53'(w2) * 53'(ecc_pkg::DIV675_LO_M);

  always_ff @(posedge clk) begin
    ql3 <= pl[51:36];
    w3  <= w2;
    qh3 <= qh2;
    lo3 <= lo2;
  end

  assign rl = w3 - 26'(ql3) * 26'(ecc_pkg::DAY_SPLIT_DIV);

  always_ff @(posedge clk) begin
    g   <= $signed({1'b0, qh3, ql3}) - ecc_pkg::DAY_BIAS;
    sod <= {rl[9:0], lo3};
  end

endmodule

`default_nettype wire

/* design/ecc_tod_split.sv */
`timescale 1ns / 1ps
`default_nettype none

// second of day into hour, minute, second, four stages
module ecc_tod_split (
  input  wire logic        clk,
  input  wire logic [16:0] sod,
  output ecc_pkg::tod_t    tod
);

  logic [25:0] ph;
  logic [4:0]  hr1, hr2, hr3;
  logic [16:0] sod1;
  logic [11:0] r2, r3;
  logic [19:0] pm;
  logic [5:0]  mn3;

  // hour = (sod / 16) / 225
  assign ph = 26'(sod[16:4]) * 26'(ecc_pkg::HOUR_M);

  always_ff @(posedge clk) begin
    hr1  <= ph[25:21];
    sod1 <= sod;
  end

  always_ff @(posedge clk) begin
    r2  <= 12'(sod1 - 17'(hr1) * 17'(ecc_pkg::SEC_PER_HOUR));
    hr2 <= hr1;
  end

  // minute = (r / 4) / 15
  assign pm = 20'(r2[11:2]) * 20'(ecc_pkg::MIN_M);

  always_ff @(posedge clk) begin
    mn3 <= pm[19:14];
    r3  <= r2;
    hr3 <= hr2;
  end

  always_ff @(posedge clk) begin
    tod.hour   <= hr3;
    tod.minute <= mn3;
    tod.second <= 6'(r3 - 12'(mn3) * 12'(ecc_pkg::SEC_PER_MIN));
  end

endmodule

`default_nettype wire

/* design/ecc_civil_split.sv */
`timescale 1ns / 1ps
`default_nettype none

// march-based day number into year, month, day, nine stages
module ecc_civil_split (
  input  wire logic signed [23:0] g,
  input  wire logic               clk,
  output ecc_pkg::date_t          date
);

  logic signed [35:0] n_full;
  logic [33:0]        n1, n2, n3;
  logic signed [23:0] g1, g2, g3, g4, g5, g6;
  logic [44:0]        pq;
  logic [14:0]        qe2, qe3;
  logic [34:0]        pp;
  logic [33:0]        pp3;
  logic [33:0]        rr;
  logic [14:0]        q;
  logic signed [15:0] y4, y5, y6, y7, y8;
  logic signed [8:0]  fa5, fb5;
  logic signed [23:0] da6, db6;
  logic signed [23:0] rem_a, rem_b;
  logic [8:0]         rem7, rem8;
  logic [15:0]        nm;
  logic [28:0]        pm;
  logic [3:0]         mi8;
  logic [3:0]         month_c;
  logic signed [15:0] year_c;

  // stage 1: biased dividend for the year estimate
  assign n_full = 36'(g) * 36'sd2000 + ecc_pkg::YEAR_NUM_BIAS;

  always_ff @(posedge clk) begin
    n1 <= n_full[33:0];
    g1 <= g;
  end

  // stage 2: truncated reciprocal, low by at most one
  assign pq = 45'(n1[33:10]) * 45'(ecc_pkg::DIV_YR_M);

  always_ff @(posedge clk) begin
    qe2 <= pq[44:30];
    n2  <= n1;
    g2  <= g1;
  end

  assign pp = 35'(qe2) * 35'(ecc_pkg::YEAR_DIV);

  always_ff @(posedge clk) begin
    pp3 <= pp[33:0];
    qe3 <= qe2;
    n3  <= n2;
    g3  <= g2;
  end

  // stage 4: remainder check fixes the quotient
  assign rr = n3 - pp3;
  assign q  = qe3 + ((rr >= 34'(ecc_pkg::YEAR_DIV)) ? 15'd1 : 15'd0);

  always_ff @(posedge clk) begin
    y4 <= $signed({1'b0, q}) - ecc_pkg::YEAR_BIAS;
    g4 <= g3;
  end

  // stages 5 and 6: year starts for the estimate and the year before
  always_ff @(posedge clk) begin
    fa5 <= ecc_pkg::div100(y4);
    fb5 <= ecc_pkg::div100(y4 - 16'sd1);
    y5  <= y4;
    g5  <= g4;
  end

  always_ff @(posedge clk) begin
    da6 <= ecc_pkg::days_before(y5, fa5);
    db6 <= ecc_pkg::days_before(y5 - 16'sd1, fb5);
    y6  <= y5;
    g6  <= g5;
  end

  // stage 7: step back one year on overshoot
  assign rem_a = g6 - da6;
  assign rem_b = g6 - db6;

  always_ff @(posedge clk) begin
    if (rem_a < 24'sd0) begin
      y7   <= y6 - 16'sd1;
      rem7 <= rem_b[8:0];
    end else begin
      y7   <= y6;
      rem7 <= rem_a[8:0];
    end
  end

  // stage 8: march-based month, (100 rem + 52) / 3060
  assign nm = 16'(rem7) * 16'd100 + 16'd52;
  assign pm = 29'(nm[15:2]) * 29'(ecc_pkg::MI_M);

  always_ff @(posedge clk) begin
    mi8  <= pm[27:24];
    rem8 <= rem7;
    y8   <= y7;
  end

  // stage 9: back to january-based month and year
  assign month_c = (mi8 >= 4'd10) ? mi8 - 4'd9 : mi8 + 4'd3;
  assign year_c  = y8 + ((mi8 >= 4'd10) ? 16'sd1 : 16'sd0);

  always_ff @(posedge clk) begin
    date.year  <= year_c[13:0];
    date.month <= month_c;
    date.day   <= 5'(rem8 - ecc_pkg::month_offset(mi8) + 9'd1);
  end

endmodule

`default_nettype wire

/* design/epoch_seconds_calendar_converter.sv */
`timescale 1ns / 1ps
`default_nettype none

// two-way converter between signed epoch seconds and a proleptic gregorian utc date.
// mode 0 turns year/month/day/hour/minute/second into seconds since 1970-01-01,
// mode 1 splits seconds into the date and time of day, with floor division so that
// times before 1970 come out right; nanoseconds pass straight through. the block is
// a fixed pipeline: one transfer is taken every clock cycle (start while busy is low,
// busy is high only during reset) and its result sits on the out_ ports, marked by
// done, for a single cycle. the receiver cannot stall, so results must be captured
// on that cycle. results come back in order. the depth is set by the seconds-to-date
// path: a two-digit division by 675 for the day split, then a reciprocal year
// estimate with a remainder correction and the one-year step back. fields that do
// not belong to the chosen mode read as zero.
module epoch_seconds_calendar_converter (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  output logic                    done,
  input  wire logic               mode,
  input  wire logic        [13:0] year,
  input  wire logic        [3:0]  month,
  input  wire logic        [4:0]  day,
  input  wire logic        [4:0]  hour,
  input  wire logic        [5:0]  minute,
  input  wire logic        [5:0]  second,
  input  wire logic        [29:0] nanosecond,
  input  wire logic signed [38:0] epoch_seconds,
  output logic signed      [38:0] out_epoch_seconds,
  output logic             [13:0] out_year,
  output logic             [3:0]  out_month,
  output logic             [4:0]  out_day,
  output logic             [4:0]  out_hour,
  output logic             [5:0]  out_minute,
  output logic             [5:0]  out_second,
  output logic             [29:0] out_nanosecond
);

  // register depths of the sub-pipelines
  localparam int JOIN_LAT  = 4;
  localparam int SPLIT_LAT = 4;
  localparam int TOD_LAT   = 4;
  localparam int CIVIL_LAT = 9;
  // the longest path sets the alignment point ahead of the output register
  localparam int LAT       = SPLIT_LAT + CIVIL_LAT;
  localparam int SECS_DLY  = LAT - JOIN_LAT;
  localparam int TOD_DLY   = LAT - SPLIT_LAT - TOD_LAT;

  logic                  accept;
  logic [LAT-1:0]        vld;
  logic                  mode_dly [LAT];
  logic [29:0]           ns_dly   [LAT];
  logic [38:0]           secs;
  logic [38:0]           secs_dly [SECS_DLY];
  logic signed [23:0]    g;
  logic [16:0]           sod;
  ecc_pkg::tod_t         tod;
  ecc_pkg::tod_t         tod_dly  [TOD_DLY];
  ecc_pkg::date_t        date;

  // no back-pressure: a transfer with start high is taken in every cycle outside reset
  assign busy   = rst;
  assign accept = start && !busy;

  // date to seconds
  ecc_date_join u_join (
    .clk    (clk),
    .year   (year),
    .month  (month),
    .day    (day),
    .hour   (hour),
    .minute (minute),
    .second (second),
    .secs   (secs)
  );

  // seconds to day number and second of day
  ecc_epoch_split u_split (
    .clk           (clk),
    .epoch_seconds (epoch_seconds),
    .g             (g),
    .sod           (sod)
  );

  // second of day to hour, minute, second
  ecc_tod_split u_tod (
    .clk (clk),
    .sod (sod),
    .tod (tod)
  );

  // day number to year, month, day
  ecc_civil_split u_civil (
    .g    (g),
    .clk  (clk),
    .date (date)
  );

  // valid bits ride alongside the arithmetic, cleared on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], accept};
    end
  end

  // mode and nanoseconds follow the same stages
  always_ff @(posedge clk) begin
    mode_dly[0] <= mode;
    ns_dly[0]   <= nanosecond;
    for (int i = 1; i < LAT; i++) begin
      mode_dly[i] <= mode_dly[i-1];
      ns_dly[i]   <= ns_dly[i-1];
    end
  end

  // the short paths wait for the date split to finish
  always_ff @(posedge clk) begin
    secs_dly[0] <= secs;
    for (int i = 1; i < SECS_DLY; i++) begin
      secs_dly[i] <= secs_dly[i-1];
    end
  end

  always_ff @(posedge clk) begin
    tod_dly[0] <= tod;
    for (int i = 1; i < TOD_DLY; i++) begin
      tod_dly[i] <= tod_dly[i-1];
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[LAT-1];
    end
  end

  // result register: pick the fields of the item's mode, zero the others
  always_ff @(posedge clk) begin
    out_nanosecond <= ns_dly[LAT-1];
    if (mode_dly[LAT-1]) begin
      out_epoch_seconds <= '0;
      out_year          <= date.year;
      out_month         <= date.month;
      out_day           <= date.day;
      out_hour          <= tod_dly[TOD_DLY-1].hour;
      out_minute        <= tod_dly[TOD_DLY-1].minute;
      out_second        <= tod_dly[TOD_DLY-1].second;
    end else begin
      out_epoch_seconds <= secs_dly[SECS_DLY-1];
      out_year          <= '0;
      out_month         <= '0;
      out_day           <= '0;
      out_hour          <= '0;
      out_minute        <= '0;
      out_second        <= '0;
    end
  end

`ifndef NO_ASSERTIONS
  // each accepted transfer returns after the fixed depth
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##(LAT + 1) done)
    else $error("accepted transfer did not return on time");

  // no result without a matching transfer
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LAT + 1))
    else $error("result without an accepted transfer");

  // nanoseconds stay paired with their item
  a_ns_aligned: assert property (@(posedge clk) disable iff (rst)
    done |-> out_nanosecond == $past(nanosecond, LAT + 1))
    else $error("nanosecond misaligned with its result");

  // only one direction's fields are populated
  a_mode_fields: assert property (@(posedge clk) disable iff (rst)
    done |-> (out_epoch_seconds == '0) ||
             (out_year == '0 && out_month == '0 && out_day == '0 &&
              out_hour == '0 && out_minute == '0 && out_second == '0))
    else $error("fields of both directions populated");

  // the constant dividers leave in-range remainders
  a_split_range: assert property (@(posedge clk) disable iff (rst)
    done |-> out_hour < 5'd24 && out_minute < 6'd60 && out_second < 6'd60 &&
             out_month <= 4'd12)
    else $error("time or month field out of range");
`endif

endmodule

`default_nettype wire

/* dv/epoch_seconds_calendar_converter_test.sv */
`timescale 1ns / 1ps

// testbench for the epoch seconds / gregorian calendar converter
module epoch_seconds_calendar_converter_test;

  // direction codes carried on the mode port
  localparam logic MODE_TO_SECONDS = 1'b0;
  localparam logic MODE_TO_DATE    = 1'b1;

  localparam int CYCLE_LIMIT = 200000;
  // wait at the end, well past the return of the last result
  localparam int SETTLE_CYCLES = 30;
  localparam int ITEMS_PER_PHASE = 175;

  localparam longint FIRST_SECOND = -64'sd62135596800;  // 0001-01-01 00:00:00
  localparam longint LAST_SECOND  = 64'sd253402300799;  // 9999-12-31 23:59:59

  // one input transfer
  typedef struct {
    logic               mode;
    logic        [13:0] year;
    logic        [3:0]  month;
    logic        [4:0]  day;
    logic        [4:0]  hour;
    logic        [5:0]  minute;
    logic        [5:0]  second;
    logic        [29:0] nanosecond;
    logic signed [38:0] epoch_seconds;
  } conv_item_t;

  // one result, as seen on the out_ ports
  typedef struct {
    logic signed [38:0] epoch_seconds;
    logic        [13:0] year;
    logic        [3:0]  month;
    logic        [4:0]  day;
    logic        [4:0]  hour;
    logic        [5:0]  minute;
    logic        [5:0]  second;
    logic        [29:0] nanosecond;
  } conv_result_t;

  typedef struct {
    conv_item_t   stim;
    conv_result_t want;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic               done;
  logic               mode = MODE_TO_SECONDS;
  logic        [13:0] year = '0;
  logic        [3:0]  month = '0;
  logic        [4:0]  day = '0;
  logic        [4:0]  hour = '0;
  logic        [5:0]  minute = '0;
  logic        [5:0]  second = '0;
  logic        [29:0] nanosecond = '0;
  logic signed [38:0] epoch_seconds = '0;
  logic signed [38:0] out_epoch_seconds;
  logic        [13:0] out_year;
  logic        [3:0]  out_month;
  logic        [4:0]  out_day;
  logic        [4:0]  out_hour;
  logic        [5:0]  out_minute;
  logic        [5:0]  out_second;
  logic        [29:0] out_nanosecond;

  conv_result_t pending_results[$];   // results still owed by the block, oldest first
  stim_row_t    directed_rows[$];
  int           mismatch_count = 0;
  int           cycle_count = 0;

  epoch_seconds_calendar_converter u_dut (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .busy              (busy),
    .done              (done),
    .mode              (mode),
    .year              (year),
    .month             (month),
    .day               (day),
    .hour              (hour),
    .minute            (minute),
    .second            (second),
    .nanosecond        (nanosecond),
    .epoch_seconds     (epoch_seconds),
    .out_epoch_seconds (out_epoch_seconds),
    .out_year          (out_year),
    .out_month         (out_month),
    .out_day           (out_day),
    .out_hour          (out_hour),
    .out_minute        (out_minute),
    .out_second        (out_second),
    .out_nanosecond    (out_nanosecond)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // calendar arithmetic, all divisions rounding towards minus infinity
  // ---------------------------------------------------------------------------

  function automatic longint floor_div(input longint a, input longint b);
    longint q;
    q = a / b;
    if ((a % b) < 0) q = q - 1;
    return q;
  endfunction

  function automatic longint floor_mod(input longint a, input longint b);
    return a - floor_div(a, b) * b;
  endfunction

  // days from march 1 of year 0 to march 1 of year y
  function automatic longint days_to_year(input longint y);
    return 365 * y + floor_div(y, 4) - floor_div(y, 100) + floor_div(y, 400);
  endfunction

  // day count of a date in a march-based year, so the leap day falls last;
  // out-of-range months fold mod 12 and day 0 is the day before the 1st
  function automatic longint march_day(input longint y, input longint m, input longint d);
    longint mm;
    mm = floor_mod(m + 9, 12);
    return days_to_year(y - mm / 10) + (mm * 306 + 5) / 10 + (d - 1);
  endfunction

  // expected result of one transfer
  function automatic conv_result_t calendar_convert(input conv_item_t it);
    conv_result_t r;
    longint epoch_day;
    longint secs;
    longint t;
    longint mins;
    longint hrs;
    longint g;
    longint y;
    longint rem;
    longint mi;
    epoch_day = march_day(1970, 1, 1);
    r = '{default: '0};
    r.nanosecond = it.nanosecond;
    if (it.mode == MODE_TO_SECONDS) begin
      secs = (march_day(longint'(it.year), longint'(it.month), longint'(it.day)) - epoch_day)
             * 86400 + longint'(it.hour) * 3600 + longint'(it.minute) * 60
             + longint'(it.second);
      r.epoch_seconds = 39'(secs);   // wraps when the date lies too far out
    end else begin
      t = longint'(it.epoch_seconds);
      r.second = 6'(floor_mod(t, 60));
      mins = floor_div(t, 60);
      r.minute = 6'(floor_mod(mins, 60));
      hrs = floor_div(mins, 60);
      r.hour = 5'(floor_mod(hrs, 24));
      g = floor_div(hrs, 24) + epoch_day;
      // year estimate, stepped back once when it overshoots
      y = floor_div(10000 * g + 14780, 3652425);
      rem = g - days_to_year(y);
      if (rem < 0) begin
        y = y - 1;
        rem = g - days_to_year(y);
      end
      mi = (100 * rem + 52) / 3060;
      r.month = 4'((mi + 2) % 12 + 1);
      r.year = 14'(y + (mi + 2) / 12);   // january and february belong to the next year
      r.day = 5'(rem - (mi * 306 + 5) / 10 + 1);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus builders
  // ---------------------------------------------------------------------------

  // date transfer; the unused seconds port carries noise
  function automatic conv_item_t date_item(input int y, input int mo, input int d,
                                           input int h, input int mi, input int s,
                                           input int ns);
    conv_item_t it;
    it.mode = MODE_TO_SECONDS;
    it.year = 14'(y);
    it.month = 4'(mo);
    it.day = 5'(d);
    it.hour = 5'(h);
    it.minute = 6'(mi);
    it.second = 6'(s);
    it.nanosecond = 30'(ns);
    it.epoch_seconds = 39'({$urandom, $urandom});
    return it;
  endfunction

  // seconds transfer; the unused date ports carry noise
  function automatic conv_item_t seconds_item(input longint t, input int ns);
    conv_item_t it;
    it = date_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, ns);
    it.mode = MODE_TO_DATE;
    it.epoch_seconds = 39'(t);
    return it;
  endfunction

  function automatic conv_result_t seconds_result(input longint t, input int ns);
    conv_result_t r;
    r = '{default: '0};
    r.epoch_seconds = 39'(t);
    r.nanosecond = 30'(ns);
    return r;
  endfunction

  function automatic conv_result_t date_result(input int y, input int mo, input int d,
                                               input int h, input int mi, input int s,
                                               input int ns);
    conv_result_t r;
    r = '{default: '0};
    r.year = 14'(y);
    r.month = 4'(mo);
    r.day = 5'(d);
    r.hour = 5'(h);
    r.minute = 6'(mi);
    r.second = 6'(s);
    r.nanosecond = 30'(ns);
    return r;
  endfunction

  function automatic longint random_between(input longint lo, input longint hi);
    longint unsigned r;
    r = {$urandom, $urandom};
    return lo + longint'(r % longint'(hi - lo + 1));
  endfunction

  // mostly legal fractions, now and then the full 30 bits
  function automatic int random_nanosecond();
    if ($urandom_range(0, 4) == 0) return int'($urandom & 32'h3fff_ffff);
    return int'($urandom_range(0, 999999999));
  endfunction

  function automatic conv_item_t random_item();
    conv_item_t   it;
    conv_result_t edge_res;
    int           pick;
    longint       t;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      // well-formed date
      it = date_item($urandom_range(1, 9999), $urandom_range(1, 12), $urandom_range(1, 31),
                     $urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 59),
                     random_nanosecond());
    end else if (pick < 45) begin
      // any bit pattern the date ports can carry
      it = date_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     random_nanosecond());
    end else if (pick < 75) begin
      it = seconds_item(random_between(FIRST_SECOND, LAST_SECOND), random_nanosecond());
    end else if (pick < 90) begin
      // within two days of a month start, where the year estimate may overshoot
      edge_res = calendar_convert(date_item($urandom_range(1, 9999), $urandom_range(1, 12),
                                            1, 0, 0, 0, 0));
      t = longint'(edge_res.epoch_seconds) + random_between(-172800, 172800);
      it = seconds_item(t, random_nanosecond());
    end else begin
      // full 39-bit range, years well before year 1 and past 9999
      it = seconds_item(longint'($signed(39'({$urandom, $urandom}))), random_nanosecond());
    end
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // present one transfer and hold it until the block takes it; start stays high
  // so a following transfer can go out on the very next edge
  task automatic issue_conversion(input conv_item_t it, input conv_result_t want);
    start <= 1'b1;
    mode <= it.mode;
    year <= it.year;
    month <= it.month;
    day <= it.day;
    hour <= it.hour;
    minute <= it.minute;
    second <= it.second;
    nanosecond <= it.nanosecond;
    epoch_seconds <= it.epoch_seconds;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(want);
  endtask

  task automatic idle_cycle();
    start <= 1'b0;
    @(posedge clk);
  endtask

  // hold off until every owed result has come back
  task automatic wait_for_results();
    idle_cycle();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // result checking: the strobe lasts one cycle, so sample on every edge
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    conv_result_t want;
    if (done === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result with no transfer outstanding");
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("out_epoch_seconds", want.epoch_seconds, out_epoch_seconds);
        check_field("out_year", want.year, out_year);
        check_field("out_month", want.month, out_month);
        check_field("out_day", want.day, out_day);
        check_field("out_hour", want.hour, out_hour);
        check_field("out_minute", want.minute, out_minute);
        check_field("out_second", want.second, out_second);
        check_field("out_nanosecond", want.nanosecond, out_nanosecond);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    int          idle_pct[4];
    conv_item_t  it;
    stim_row_t   row;

    // sender idling per phase: none, heavy, none, light
    idle_pct = '{0, 68, 0, 33};

    // directed rows: well-known instants typed in, the odd cases left to the predictor
    row.stim = date_item(1970, 1, 1, 0, 0, 0, 0);
    row.want = seconds_result(0, 0);
    directed_rows.push_back(row);
    row.stim = seconds_item(0, 0);
    row.want = date_result(1970, 1, 1, 0, 0, 0, 0);
    directed_rows.push_back(row);
    // one second before the epoch, floor division must borrow a whole day
    row.stim = seconds_item(-1, 999999999);
    row.want = date_result(1969, 12, 31, 23, 59, 59, 999999999);
    directed_rows.push_back(row);
    row.stim = date_item(1969, 12, 31, 23, 59, 59, 1);
    row.want = seconds_result(-1, 1);
    directed_rows.push_back(row);
    row.stim = date_item(9999, 12, 31, 23, 59, 59, 999999999);
    row.want = seconds_result(LAST_SECOND, 999999999);
    directed_rows.push_back(row);
    row.stim = date_item(1, 1, 1, 0, 0, 0, 0);
    row.want = seconds_result(FIRST_SECOND, 0);
    directed_rows.push_back(row);
    row.stim = seconds_item(LAST_SECOND, 123456789);
    row.want = date_result(9999, 12, 31, 23, 59, 59, 123456789);
    directed_rows.push_back(row);
    row.stim = seconds_item(FIRST_SECOND, 0);
    row.want = date_result(1, 1, 1, 0, 0, 0, 0);
    directed_rows.push_back(row);
    // leap day of a leap century
    row.stim = date_item(2000, 2, 29, 0, 0, 0, 0);
    row.want = seconds_result(951782400, 0);
    directed_rows.push_back(row);
    row.stim = seconds_item(951782400, 0);
    row.want = date_result(2000, 2, 29, 0, 0, 0, 0);
    directed_rows.push_back(row);
    row.stim = seconds_item(951868799, 0);
    row.want = date_result(2000, 2, 29, 23, 59, 59, 0);
    directed_rows.push_back(row);
    directed_rows.push_back(row);   // back to back repeat
    // rest through the predictor: extremes of the ports and unchecked date fields
    row.stim = seconds_item(longint'(64'sd274877906943), 32'h3fff_ffff);
    directed_rows.push_back(row);
    row.stim = seconds_item(-longint'(64'sd274877906944), 0);
    directed_rows.push_back(row);
    row.stim = seconds_item(FIRST_SECOND - 1, 0);   // last second of year 0
    directed_rows.push_back(row);
    row.stim = date_item(0, 0, 0, 0, 0, 0, 0);
    directed_rows.push_back(row);
    row.stim = date_item(16383, 15, 31, 31, 63, 63, 32'h3fff_ffff);
    directed_rows.push_back(row);
    row.stim = date_item(1900, 2, 29, 12, 0, 0, 0);   // not a leap year, rolls into march
    directed_rows.push_back(row);
    row.stim = date_item(2024, 13, 1, 0, 0, 0, 0);
    directed_rows.push_back(row);
    row.stim = date_item(2024, 14, 30, 0, 0, 0, 0);
    directed_rows.push_back(row);
    row.stim = date_item(2023, 0, 15, 6, 30, 0, 0);
    directed_rows.push_back(row);
    row.stim = date_item(2100, 3, 1, 0, 0, 0, 0);
    directed_rows.push_back(row);
    for (int i = 12; i < directed_rows.size(); i++) begin
      directed_rows[i].want = calendar_convert(directed_rows[i].stim);
    end

    // reset, then wait for the block to come ready
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (busy) @(posedge clk);

    foreach (directed_rows[i]) begin
      issue_conversion(directed_rows[i].stim, directed_rows[i].want);
    end
    wait_for_results();

    for (int phase = 0; phase < 4; phase++) begin
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        while ($urandom_range(1, 100) <= idle_pct[phase]) idle_cycle();
        it = random_item();
        issue_conversion(it, calendar_convert(it));
      end
      // pipeline runs dry between phases
      wait_for_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* files.f */
design/ecc_pkg.sv
design/ecc_date_join.sv
design/ecc_epoch_split.sv
design/ecc_tod_split.sv
design/ecc_civil_split.sv
design/epoch_seconds_calendar_converter.sv
dv/epoch_seconds_calendar_converter_test.sv
